/* rtl/pma_pkg.sv */
// Shared types, codes and sizes for the page map allocator.
// No dependencies; used by pma_ctrl, pma_dpath and page_map_allocator.
`default_nettype none

package pma_pkg;

   // Map geometry
   localparam int PAGES   = 256;
   localparam int PAGE_AW = $clog2(PAGES);
   localparam int CNT_W   = 9;            // page_count, align_pages, page_limit
   localparam int POS_W   = CNT_W + 1;    // scan positions and aligned restarts

   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(PAGES);

   // Page states
   localparam logic [1:0] PG_FREE   = 2'd0;
   localparam logic [1:0] PG_EXCL   = 2'd1;
   localparam logic [1:0] PG_SHARED = 2'd2;

   // Request kinds
   localparam logic [1:0] KIND_ALLOC = 2'd0;
   localparam logic [1:0] KIND_FREE  = 2'd1;
   localparam logic [1:0] KIND_LOCK  = 2'd2;

   // Response status codes
   localparam logic [1:0] RSP_OK       = 2'd0;
   localparam logic [1:0] RSP_NO_SPACE = 2'd1;
   localparam logic [1:0] RSP_BUSY     = 2'd2;
   localparam logic [1:0] RSP_RANGE    = 2'd3;

   // Datapath operations
   localparam logic [3:0] OP_NONE        = 4'd0;
   localparam logic [3:0] OP_LOAD        = 4'd1;
   localparam logic [3:0] OP_CLEAR       = 4'd2;
   localparam logic [3:0] OP_RUN_START   = 4'd3;
   localparam logic [3:0] OP_STEP        = 4'd4;
   localparam logic [3:0] OP_BREAK       = 4'd5;
   localparam logic [3:0] OP_ALIGN_ADD   = 4'd6;
   localparam logic [3:0] OP_ALIGN_SET   = 4'd7;
   localparam logic [3:0] OP_FILL_S      = 4'd8;
   localparam logic [3:0] OP_FILL_B      = 4'd9;
   localparam logic [3:0] OP_FILL        = 4'd10;
   localparam logic [3:0] OP_RANGE_START = 4'd11;
   localparam logic [3:0] OP_OUT         = 4'd12;

   typedef struct packed {
      logic [3:0] op;
      logic       set_res;     // latch res_code into the result register
      logic [1:0] res_code;
      logic       res_at_s;    // result page is the run start, else 0
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       shared;
      logic       clr_last;
      logic       count_zero;
      logic       range_bad;
      logic       s_ge_max;
      logic       p_alloc;     // page just read is exclusively held
      logic       p_used;      // page just read is not free
      logic       run_last;    // page just read completes the run
      logic       next_ge_max;
      logic       align_on;
      logic       m_le_s;
      logic       fill_last;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/pma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pma_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/pma_ctrl.sv */
// Sequencer for the page map allocator: handshakes and operation order.
// Depends on pma_pkg (cmd_type, sts_type, op and status codes).
`default_nettype none

module pma_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire pma_pkg::sts_type sts,
   output      pma_pkg::cmd_type cmd
);

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_DISPATCH = 4'd2;
   localparam logic [3:0] ST_A_START  = 4'd3;
   localparam logic [3:0] ST_A_SCAN   = 4'd4;
   localparam logic [3:0] ST_A_ALIGN  = 4'd5;
   localparam logic [3:0] ST_L_SCAN   = 4'd6;
   localparam logic [3:0] ST_FILL     = 4'd7;
   localparam logic [3:0] ST_RESP     = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       blocked;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign blocked   = sts.shared ? sts.p_alloc : sts.p_used;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = pma_pkg::OP_CLEAR;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = pma_pkg::OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (sts.kind)
               pma_pkg::KIND_ALLOC: begin
                  state_in = ST_A_START;
               end
               pma_pkg::KIND_FREE, pma_pkg::KIND_LOCK: begin
                  cmd.set_res = 1'b1;
                  if (sts.range_bad) begin
                     cmd.res_code = pma_pkg::RSP_RANGE;
                     state_in     = ST_RESP;
                  end else if (sts.count_zero) begin
                     cmd.res_code = pma_pkg::RSP_OK;
                     state_in     = ST_RESP;
                  end else if (sts.kind == pma_pkg::KIND_FREE) begin
                     cmd.res_code = pma_pkg::RSP_OK;
                     cmd.op       = pma_pkg::OP_FILL_B;
                     state_in     = ST_FILL;
                  end else begin
                     cmd.set_res = 1'b0;
                     cmd.op      = pma_pkg::OP_RANGE_START;
                     state_in    = ST_L_SCAN;
                  end
               end
               default: begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = pma_pkg::RSP_OK;
                  state_in     = ST_RESP;
               end
            endcase
         end
         ST_L_SCAN: begin
            if (sts.p_alloc) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = pma_pkg::RSP_BUSY;
               state_in     = ST_RESP;
            end else if (sts.run_last) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = pma_pkg::RSP_OK;
               cmd.op       = pma_pkg::OP_FILL_B;
               state_in     = ST_FILL;
            end else begin
               cmd.op = pma_pkg::OP_STEP;
            end
         end
         ST_A_START: begin
            if (sts.s_ge_max) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = pma_pkg::RSP_NO_SPACE;
               state_in     = ST_RESP;
            end else if (sts.count_zero) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = pma_pkg::RSP_OK;
               cmd.res_at_s = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.op   = pma_pkg::OP_RUN_START;
               state_in = ST_A_SCAN;
            end
         end
         ST_A_SCAN: begin
            if (blocked) begin
               cmd.op   = pma_pkg::OP_BREAK;
               state_in = sts.align_on ? ST_A_ALIGN : ST_A_START;
            end else if (sts.run_last) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = pma_pkg::RSP_OK;
               cmd.res_at_s = 1'b1;
               cmd.op       = pma_pkg::OP_FILL_S;
               state_in     = ST_FILL;
            end else if (sts.next_ge_max) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = pma_pkg::RSP_NO_SPACE;
               state_in     = ST_RESP;
            end else begin
               cmd.op = pma_pkg::OP_STEP;
            end
         end
         ST_A_ALIGN: begin
            // walk the multiple up until it passes the restart point
            if (sts.m_le_s) begin
               cmd.op = pma_pkg::OP_ALIGN_ADD;
            end else begin
               cmd.op   = pma_pkg::OP_ALIGN_SET;
               state_in = ST_A_START;
            end
         end
         ST_FILL: begin
            cmd.op = pma_pkg::OP_FILL;
            if (sts.fill_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = pma_pkg::OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff & ~rsp_ready) | (cmd.op == pma_pkg::OP_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/pma_dpath.sv */
// Datapath of the page map allocator: request registers, scan counters,
// alignment stepper, page map RAM and result registers.
// Depends on pma_pkg and pma_ram.
`default_nettype none

module pma_dpath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [1:0]                   req_kind,
   input  wire logic [pma_pkg::CNT_W-1:0]    req_page_count,
   input  wire logic [pma_pkg::CNT_W-1:0]    req_align_pages,
   input  wire logic                         req_shared,
   input  wire logic [pma_pkg::PAGE_AW-1:0]  req_base_page,
   input  wire logic                         csr_wr_en,
   input  wire logic [pma_pkg::CNT_W-1:0]    csr_wr_data,
   input  wire pma_pkg::cmd_type             cmd,
   output      pma_pkg::sts_type             sts,
   output      logic [1:0]                   rsp_status,
   output      logic [pma_pkg::PAGE_AW-1:0]  rsp_found_page
);

   localparam int AW = pma_pkg::PAGE_AW;
   localparam int CW = pma_pkg::CNT_W;
   localparam int PW = pma_pkg::POS_W;

   // request payload
   logic [1:0]    kind_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] align_ff;
   logic          sh_ff;
   logic [AW-1:0] base_ff;

   logic [CW-1:0] limit_ff;

   // scan state: run start, aligned multiple, current page, pages left
   logic [PW-1:0] s_ff, s_in;
   logic [PW-1:0] m_ff, m_in;
   logic [PW-1:0] l_ff, l_in;
   logic [CW-1:0] c_ff, c_in;
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [CW-1:0] wc_ff, wc_in;
   logic [AW-1:0] clr_ff;

   logic [1:0]    res_status_ff;
   logic [AW-1:0] res_found_ff;
   logic [1:0]    rsp_status_ff;
   logic [AW-1:0] rsp_found_ff;

   logic [CW-1:0] max_lim;
   logic [PW-1:0] l_next;
   logic [PW-1:0] range_end;
   logic [1:0]    mark;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [1:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [1:0]    ram_rdata;

   assign max_lim   = (limit_ff > pma_pkg::LIMIT_RESET) ? pma_pkg::LIMIT_RESET : limit_ff;
   assign l_next    = l_ff + PW'(1);
   assign range_end = PW'(base_ff) + PW'(count_ff);

   always_comb begin
      case (kind_ff)
         pma_pkg::KIND_ALLOC: mark = sh_ff ? pma_pkg::PG_SHARED : pma_pkg::PG_EXCL;
         pma_pkg::KIND_FREE:  mark = pma_pkg::PG_FREE;
         default:             mark = pma_pkg::PG_EXCL;
      endcase
   end

   always_comb begin
      s_in      = s_ff;
      m_in      = m_ff;
      l_in      = l_ff;
      c_in      = c_ff;
      wptr_in   = wptr_ff;
      wc_in     = wc_ff;
      ram_we    = 1'b0;
      ram_waddr = wptr_ff;
      ram_wdata = mark;
      ram_raddr = l_ff[AW-1:0];
      case (cmd.op)
         pma_pkg::OP_LOAD: begin
            s_in = '0;
            m_in = '0;
         end
         pma_pkg::OP_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = pma_pkg::PG_FREE;
         end
         pma_pkg::OP_RUN_START: begin
            l_in      = s_ff;
            c_in      = count_ff;
            ram_raddr = s_ff[AW-1:0];
         end
         pma_pkg::OP_RANGE_START: begin
            l_in      = PW'(base_ff);
            c_in      = count_ff;
            ram_raddr = base_ff;
         end
         pma_pkg::OP_STEP: begin
            l_in      = l_next;
            c_in      = c_ff - CW'(1);
            ram_raddr = l_next[AW-1:0];
         end
         pma_pkg::OP_BREAK: begin
            s_in = l_next;
         end
         pma_pkg::OP_ALIGN_ADD: begin
            m_in = m_ff + PW'(align_ff);
         end
         pma_pkg::OP_ALIGN_SET: begin
            s_in = m_ff;
         end
         pma_pkg::OP_FILL_S: begin
            wptr_in = s_ff[AW-1:0];
            wc_in   = count_ff;
         end
         pma_pkg::OP_FILL_B: begin
            wptr_in = base_ff;
            wc_in   = count_ff;
         end
         pma_pkg::OP_FILL: begin
            ram_we  = 1'b1;
            wptr_in = wptr_ff + AW'(1);
            wc_in   = wc_ff - CW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= pma_pkg::LIMIT_RESET;
         clr_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.op == pma_pkg::OP_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == pma_pkg::OP_LOAD) begin
         kind_ff  <= req_kind;
         count_ff <= req_page_count;
         align_ff <= req_align_pages;
         sh_ff    <= req_shared;
         base_ff  <= req_base_page;
      end
      s_ff    <= s_in;
      m_ff    <= m_in;
      l_ff    <= l_in;
      c_ff    <= c_in;
      wptr_ff <= wptr_in;
      wc_ff   <= wc_in;
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_code;
         res_found_ff  <= cmd.res_at_s ? s_ff[AW-1:0] : '0;
      end
      if (cmd.op == pma_pkg::OP_OUT) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
      end
   end

   pma_ram #(
      .WIDTH (2),
      .DEPTH (pma_pkg::PAGES)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      sts.kind        = kind_ff;
      sts.shared      = sh_ff;
      sts.clr_last    = (clr_ff == AW'(pma_pkg::PAGES - 1));
      sts.count_zero  = (count_ff == '0);
      sts.range_bad   = (range_end > PW'(max_lim));
      sts.s_ge_max    = (s_ff >= PW'(max_lim));
      sts.p_alloc     = (ram_rdata == pma_pkg::PG_EXCL);
      sts.p_used      = (ram_rdata != pma_pkg::PG_FREE);
      sts.run_last    = (c_ff == CW'(1));
      sts.next_ge_max = (l_next >= PW'(max_lim));
      sts.align_on    = (align_ff > CW'(1));
      sts.m_le_s      = (m_ff <= s_ff);
      sts.fill_last   = (wc_ff == CW'(1));
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_found_page = rsp_found_ff;

endmodule

`default_nettype wire

/* rtl/page_map_allocator.sv */
// Top level of the page map allocator: sequencer plus datapath.
// Depends on pma_pkg, pma_ctrl, pma_dpath (and pma_ram below it).
//
//   Port group  Dir  Handshake          Payload
//   req_*       in   req_valid/ready    kind, page_count, align_pages, shared, base_page
//   rsp_*       out  rsp_valid/ready    status, found_page
//   csr_*       in   csr_wr_en          csr_wr_data -> page_limit (9 bits)
//
// One request at a time; the 256 x 2 page map RAM has one write and one
// registered read port, so scans and fills touch one page a cycle.
// A free fills its range; a lock scans its range and fills it unless a page is held
// exclusively; an allocate scans, restarts past blocked pages, aligns, then fills.
// Reset starts a clearing pass over all 256 pages; req_ready is low, csr writes taken.
// A response stalled in the output register holds the next one in the core.
`default_nettype none

module page_map_allocator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [1:0]                  req_kind,
   input  wire logic [pma_pkg::CNT_W-1:0]   req_page_count,
   input  wire logic [pma_pkg::CNT_W-1:0]   req_align_pages,
   input  wire logic                        req_shared,
   input  wire logic [pma_pkg::PAGE_AW-1:0] req_base_page,
   // response channel
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [1:0]                  rsp_status,
   output      logic [pma_pkg::PAGE_AW-1:0] rsp_found_page,
   // page_limit register
   input  wire logic                        csr_wr_en,
   input  wire logic [pma_pkg::CNT_W-1:0]   csr_wr_data
);

   pma_pkg::cmd_type cmd;
   pma_pkg::sts_type sts;

   // sequencer: owns both handshakes and the response valid flag
   pma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: captures the request on transfer, runs scans and fills
   pma_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_kind        (req_kind),
      .req_page_count  (req_page_count),
      .req_align_pages (req_align_pages),
      .req_shared      (req_shared),
      .req_base_page   (req_base_page),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_status      (rsp_status),
      .rsp_found_page  (rsp_found_page)
   );

endmodule

`default_nettype wire
